### rtl/core/telemetry_frame_receiver_top_assert.svh
// Assertion macros used by the telemetry frame receiver top level.
`ifndef TELEMETRY_FRAME_RECEIVER_TOP_ASSERT_SVH
`define TELEMETRY_FRAME_RECEIVER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define TFR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define TFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TFR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define TFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/core/tfr_pkg.sv
// Package with types, constants and codes of the telemetry frame receiver.
package tfr_pkg;

    // Default sizes.
    localparam int DEF_MAX_DATA      = 32;
    localparam int DEF_HANDLER_COUNT = 16;

    // Fixed field widths.
    localparam int BYTE_W      = 8;
    localparam int PLEN_W      = 6;
    localparam int BIDX_W      = 5;
    localparam int MASK_W      = 16;
    localparam int MASK_IDX_W  = $clog2(MASK_W);
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // The length byte counts id and sequence besides the payload.
    localparam int MIN_LEN = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_USE_STUFFING   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_CODE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE_CODE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ESC_START_CODE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ESC_ESC_CODE   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_HANDLER_MASK   = 3'd5;

    // Configuration reset values.
    localparam logic              RST_USE_STUFFING   = 1'b1;
    localparam logic [BYTE_W-1:0] RST_START_CODE     = 8'd126;
    localparam logic [BYTE_W-1:0] RST_ESCAPE_CODE    = 8'd125;
    localparam logic [BYTE_W-1:0] RST_ESC_START_CODE = 8'd94;
    localparam logic [BYTE_W-1:0] RST_ESC_ESC_CODE   = 8'd93;
    localparam logic [MASK_W-1:0] RST_HANDLER_MASK   = 16'd0;

    // Byte substitution selects for the destuffer.
    localparam logic [1:0] SEL_RAW    = 2'd0;
    localparam logic [1:0] SEL_START  = 2'd1;
    localparam logic [1:0] SEL_ESCAPE = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic [1:0] sel;
        logic       load_len;
        logic       store_byte;
        logic       start_release;
        logic       rd_en;
        logic       rd_advance;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic use_stuffing;
        logic raw_is_escape;
        logic raw_is_esc_start;
        logic raw_is_esc_escape;
        logic dec_is_start;
        logic len_ok;
        logic fill_last;
        logic sum_ok;
        logic id_ok;
        logic plen_zero;
        logic rd_last;
    } t_dp_status;

    // One result item.
    typedef struct packed {
        logic [BYTE_W-1:0] frame_id;
        logic [BYTE_W-1:0] frame_seq;
        logic [PLEN_W-1:0] payload_len;
        logic [BIDX_W-1:0] byte_index;
        logic [BYTE_W-1:0] payload_byte;
        logic              has_payload;
        logic              last;
    } t_tfr_result;

endpackage

### rtl/core/tfr_in_if.sv
// Valid/ready channel carrying received serial bytes.
interface tfr_in_if
    import tfr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

### rtl/core/tfr_out_if.sv
// Valid/ready channel carrying released frame results.
interface tfr_out_if
    import tfr_pkg::*;
();
    logic        valid;
    logic        ready;
    t_tfr_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/tfr_ctrl.sv
// Controller state machine: receive phases, escape tracking and frame release.
module tfr_ctrl
    import tfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_dp_cmd    o_cmd
);

    localparam logic [2:0] ST_HUNT = 3'd0;
    localparam logic [2:0] ST_LEN  = 3'd1;
    localparam logic [2:0] ST_DATA = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_READ = 3'd4;
    localparam logic [2:0] ST_SEND = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_esc_pending;
    logic       n_esc_pending;
    logic       do_phase;

    // Next state and datapath commands.
    always_comb begin
        n_state       = r_state;
        n_esc_pending = r_esc_pending;
        o_cmd         = '0;
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        do_phase      = 1'b0;
        case (r_state)
            ST_HUNT, ST_LEN, ST_DATA, ST_SUM: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    do_phase = 1'b1;
                    // Escape removal ahead of the phase logic.
                    if (i_status.use_stuffing) begin
                        if (r_esc_pending) begin
                            n_esc_pending = 1'b0;
                            if (i_status.raw_is_esc_start) begin
                                o_cmd.sel = SEL_START;
                            end else if (i_status.raw_is_esc_escape) begin
                                o_cmd.sel = SEL_ESCAPE;
                            end else begin
                                do_phase = 1'b0;
                                n_state  = ST_HUNT;
                            end
                        end else if (i_status.raw_is_escape) begin
                            n_esc_pending = 1'b1;
                            do_phase      = 1'b0;
                        end
                    end
                    if (do_phase) begin
                        case (r_state)
                            ST_HUNT: begin
                                if (i_status.dec_is_start) begin
                                    n_state = ST_LEN;
                                end
                            end
                            ST_LEN: begin
                                if (i_status.len_ok) begin
                                    o_cmd.load_len = 1'b1;
                                    n_state        = ST_DATA;
                                end else begin
                                    n_state       = ST_HUNT;
                                    n_esc_pending = 1'b0;
                                end
                            end
                            ST_DATA: begin
                                o_cmd.store_byte = 1'b1;
                                if (i_status.fill_last) begin
                                    n_state = ST_SUM;
                                end
                            end
                            default: begin
                                if (i_status.sum_ok && i_status.id_ok) begin
                                    o_cmd.start_release = 1'b1;
                                    n_state = i_status.plen_zero ? ST_SEND : ST_READ;
                                end else begin
                                    n_state = ST_HUNT;
                                end
                            end
                        endcase
                    end
                end
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ST_SEND;
            end
            ST_SEND: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_status.rd_last) begin
                        n_state = ST_HUNT;
                    end else begin
                        o_cmd.rd_advance = 1'b1;
                        n_state          = ST_READ;
                    end
                end
            end
            default: begin
                n_state       = ST_HUNT;
                n_esc_pending = 1'b0;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_HUNT;
            r_esc_pending <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_esc_pending <= n_esc_pending;
        end
    end

endmodule

### rtl/core/tfr_datapath.sv
// Datapath: configuration, destuffing, frame buffer, checksum and result fields.
module tfr_datapath
    import tfr_pkg::*;
#(
    parameter int MAX_DATA      = DEF_MAX_DATA,
    parameter int HANDLER_COUNT = DEF_HANDLER_COUNT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [BYTE_W-1:0]      i_rx_byte,
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status,
    output t_tfr_result            o_result
);

    // Length counter width holds MAX_DATA + 2; address width covers the payload.
    localparam int LW = $clog2(MAX_DATA + MIN_LEN + 1);
    localparam int AW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
    localparam logic [BYTE_W-1:0] LEN_MAX   = BYTE_W'(MAX_DATA + MIN_LEN);
    localparam logic [BYTE_W-1:0] LEN_MIN   = BYTE_W'(MIN_LEN);
    localparam logic [BYTE_W-1:0] ID_LIMIT  = BYTE_W'(HANDLER_COUNT);
    localparam logic [BYTE_W-1:0] MASK_LIM  = BYTE_W'(MASK_W);
    localparam logic [LW-1:0]     HDR_BYTES = LW'(MIN_LEN);

    logic              r_use_stuffing;
    logic [BYTE_W-1:0] r_start_code;
    logic [BYTE_W-1:0] r_escape_code;
    logic [BYTE_W-1:0] r_esc_start_code;
    logic [BYTE_W-1:0] r_esc_esc_code;
    logic [MASK_W-1:0] r_handler_mask;

    logic [LW-1:0]     r_len;
    logic [LW-1:0]     r_fill;
    logic [BYTE_W-1:0] r_sum;
    logic [BYTE_W-1:0] r_id;
    logic [BYTE_W-1:0] r_seq;
    logic [LW-1:0]     r_rd_idx;
    logic [BYTE_W-1:0] r_rd_data;
    logic [BYTE_W-1:0] mem [MAX_DATA];

    logic [BYTE_W-1:0] dec_byte;
    logic [LW-1:0]     plen;
    logic [LW-1:0]     wr_pos;
    logic              plen_zero;
    logic              rd_last;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_stuffing   <= RST_USE_STUFFING;
            r_start_code     <= RST_START_CODE;
            r_escape_code    <= RST_ESCAPE_CODE;
            r_esc_start_code <= RST_ESC_START_CODE;
            r_esc_esc_code   <= RST_ESC_ESC_CODE;
            r_handler_mask   <= RST_HANDLER_MASK;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_USE_STUFFING:   r_use_stuffing   <= i_cfg_data[0];
                CFG_START_CODE:     r_start_code     <= i_cfg_data[BYTE_W-1:0];
                CFG_ESCAPE_CODE:    r_escape_code    <= i_cfg_data[BYTE_W-1:0];
                CFG_ESC_START_CODE: r_esc_start_code <= i_cfg_data[BYTE_W-1:0];
                CFG_ESC_ESC_CODE:   r_esc_esc_code   <= i_cfg_data[BYTE_W-1:0];
                CFG_HANDLER_MASK:   r_handler_mask   <= i_cfg_data[MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Destuffed byte as chosen by the controller.
    always_comb begin
        case (i_cmd.sel)
            SEL_START:  dec_byte = r_start_code;
            SEL_ESCAPE: dec_byte = r_escape_code;
            default:    dec_byte = i_rx_byte;
        endcase
    end

    assign plen      = r_len - HDR_BYTES;
    assign wr_pos    = r_fill - HDR_BYTES;
    assign plen_zero = (plen == '0);
    assign rd_last   = plen_zero || (LW'(r_rd_idx + 1'b1) == plen);

    // Status toward the controller.
    always_comb begin
        o_status.use_stuffing      = r_use_stuffing;
        o_status.raw_is_escape     = (i_rx_byte == r_escape_code);
        o_status.raw_is_esc_start  = (i_rx_byte == r_esc_start_code);
        o_status.raw_is_esc_escape = (i_rx_byte == r_esc_esc_code);
        o_status.dec_is_start      = (dec_byte == r_start_code);
        o_status.len_ok            = (dec_byte >= LEN_MIN) && (dec_byte <= LEN_MAX);
        o_status.fill_last         = (LW'(r_fill + 1'b1) == r_len);
        o_status.sum_ok            = (r_sum == dec_byte);
        o_status.id_ok             = (r_id < ID_LIMIT) && (r_id < MASK_LIM)
                                     && r_handler_mask[r_id[MASK_IDX_W-1:0]];
        o_status.plen_zero         = plen_zero;
        o_status.rd_last           = rd_last;
    end

    // Frame length, fill counter, running checksum and header bytes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_fill <= '0;
            r_sum  <= '0;
        end else if (i_cmd.load_len) begin
            r_len  <= LW'(dec_byte);
            r_fill <= '0;
            r_sum  <= '0;
        end else if (i_cmd.store_byte) begin
            r_fill <= r_fill + 1'b1;
            r_sum  <= r_sum ^ dec_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_byte && (r_fill == '0)) begin
            r_id <= dec_byte;
        end
        if (i_cmd.store_byte && (r_fill == LW'(1))) begin
            r_seq <= dec_byte;
        end
    end

    // Payload buffer with a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_byte && (r_fill >= HDR_BYTES)) begin
            mem[wr_pos[AW-1:0]] <= dec_byte;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[r_rd_idx[AW-1:0]];
        end
    end

    // Release read pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
        end else if (i_cmd.start_release) begin
            r_rd_idx <= '0;
        end else if (i_cmd.rd_advance) begin
            r_rd_idx <= r_rd_idx + 1'b1;
        end
    end

    // Result fields, stable while the controller presents them.
    always_comb begin
        o_result.frame_id     = r_id;
        o_result.frame_seq    = r_seq;
        o_result.payload_len  = PLEN_W'(plen);
        o_result.byte_index   = BIDX_W'(r_rd_idx);
        o_result.payload_byte = plen_zero ? '0 : r_rd_data;
        o_result.has_payload  = !plen_zero;
        o_result.last         = rd_last;
    end

endmodule

### rtl/core/telemetry_frame_receiver_top.sv
// Top level of the telemetry frame receiver.
//
// Usage: raw serial bytes arrive on the i_rx channel, one byte per transaction.
// With stuffing enabled, escape sequences are removed first. The receiver hunts
// for the start byte, checks the length byte, buffers id, sequence and payload,
// and compares the XOR of those bytes with the checksum byte. A good frame whose
// id is enabled in the handler mask leaves on o_res as one transaction per
// payload byte, or one transaction for an empty payload.
// Throughput: one input byte per cycle while receiving. During a release the
// input is held off; each result is a read of the payload buffer (ST_READ)
// and then the presented result (ST_SEND), and an empty frame goes straight
// to its presented result. An empty frame's result is presented in the cycle
// right after the checksum byte is accepted; otherwise a read of the payload
// buffer comes first.
// A stall on o_res holds the current result and keeps i_rx not ready.
// Reset (synchronous, active low) restores the default configuration and
// returns to hunting; the payload buffer needs no clearing pass.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data while
// the block is idle.
module telemetry_frame_receiver_top
    import tfr_pkg::*;
#(
    parameter int MAX_DATA      = DEF_MAX_DATA,
    parameter int HANDLER_COUNT = DEF_HANDLER_COUNT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    tfr_in_if.sink                 i_rx,
    tfr_out_if.source              o_res,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_dp_cmd     cmd;
    t_dp_status  status;
    t_tfr_result result;
    logic        in_ready;
    logic        out_valid;

    // Controller.
    tfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_rx.valid),
        .i_out_ready (o_res.ready),
        .i_status    (status),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    // Datapath.
    tfr_datapath #(
        .MAX_DATA      (MAX_DATA),
        .HANDLER_COUNT (HANDLER_COUNT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rx_byte   (i_rx.rx_byte),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_result    (result)
    );

    assign i_rx.ready  = in_ready;
    assign o_res.valid = out_valid;
    assign o_res.data  = result;

    // Checks on the block's own behavior.
`include "telemetry_frame_receiver_top_assert.svh"

    `TFR_ASSERT_IMPL(a_no_rx_during_release, i_clk, i_rst_n, o_res.valid, !i_rx.ready, "input taken during release")
    `TFR_ASSERT_NEXT(a_ready_after_last, i_clk, i_rst_n, o_res.valid && o_res.ready && o_res.data.last, i_rx.ready, "receiver not back after last result")
    `TFR_ASSERT_IMPL(a_empty_is_last, i_clk, i_rst_n, o_res.valid && !o_res.data.has_payload, o_res.data.last && (o_res.data.payload_len == '0), "empty frame result malformed")
    `TFR_ASSERT_NEXT(a_release_steps, i_clk, i_rst_n, o_res.valid && o_res.ready && !o_res.data.last, !o_res.valid && !i_rx.ready, "release sequence broken")

endmodule

### verif/telemetry_frame_receiver_top_tb.sv
// Self-checking testbench for the telemetry frame receiver: frames, errors and settings.
`timescale 1ns / 1ps

module telemetry_frame_receiver_top_tb;
    import tfr_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_LEN       = DEF_MAX_DATA + MIN_LEN;
    localparam int PHASE_BYTES   = 45;

    // Register indexes that decode to no register.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef enum logic [1:0] {
        RX_HUNT,
        RX_LENGTH,
        RX_BODY,
        RX_CHECK
    } rx_phase_e;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    tfr_in_if  rx_if ();
    tfr_out_if res_if ();

    telemetry_frame_receiver_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (rx_if),
        .o_res       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the configuration registers.
    logic              cfg_stuffing;
    logic [BYTE_W-1:0] cfg_start;
    logic [BYTE_W-1:0] cfg_escape;
    logic [BYTE_W-1:0] cfg_esc_start;
    logic [BYTE_W-1:0] cfg_esc_escape;
    logic [MASK_W-1:0] cfg_mask;

    // Shadow copy of the receiver state.
    rx_phase_e         rcv_phase;
    logic              rcv_esc_pending;
    logic [PLEN_W-1:0] rcv_len;
    logic [PLEN_W-1:0] rcv_fill;
    logic [BYTE_W-1:0] rcv_store [MAX_LEN];

    // Results owed by the receiver, oldest first.
    t_tfr_result due_results [$];

    // Frame under construction, as it goes on the line.
    logic [BYTE_W-1:0] line_bytes [$];
    logic [BYTE_W-1:0] pay_buf [DEF_MAX_DATA];

    int  error_count     = 0;
    int  cycle_count     = 0;
    int  bytes_accepted  = 0;
    int  frames_sent     = 0;
    int  results_checked = 0;
    int  settings_used   = 0;
    bit  rx_idle_on      = 1'b1;
    bit  res_stall_on    = 1'b1;

    // Free-running clock.
    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, due_results.size());
            $display("status: fail");
            $finish;
        end
    end

    // Back to hunting after a framing error.
    function automatic void restart_hunt();
        rcv_phase       = RX_HUNT;
        rcv_esc_pending = 1'b0;
        rcv_fill        = '0;
    endfunction

    // Work out what one accepted line byte releases and queue it.
    function automatic void deframe_byte(input logic [BYTE_W-1:0] raw);
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] id;
        t_tfr_result       r;
        int                plen;
        b = raw;
        // Destuffing ahead of the framer.
        if (cfg_stuffing) begin
            if (rcv_esc_pending) begin
                rcv_esc_pending = 1'b0;
                if (b == cfg_esc_start) begin
                    b = cfg_start;
                end else if (b == cfg_esc_escape) begin
                    b = cfg_escape;
                end else begin
                    restart_hunt();
                    return;
                end
            end else if (b == cfg_escape) begin
                rcv_esc_pending = 1'b1;
                return;
            end
        end
        case (rcv_phase)
            RX_HUNT: begin
                if (b == cfg_start) rcv_phase = RX_LENGTH;
            end
            RX_LENGTH: begin
                if (b < MIN_LEN || b > MAX_LEN) begin
                    restart_hunt();
                end else begin
                    rcv_len   = PLEN_W'(b);
                    rcv_fill  = '0;
                    rcv_phase = RX_BODY;
                end
            end
            RX_BODY: begin
                rcv_store[rcv_fill] = b;
                rcv_fill++;
                if (rcv_fill >= rcv_len) rcv_phase = RX_CHECK;
            end
            default: begin
                rcv_phase = RX_HUNT;
                sum = '0;
                for (int i = 0; i < rcv_len; i++) sum ^= rcv_store[i];
                id = rcv_store[0];
                if (sum != b || id >= DEF_HANDLER_COUNT || !cfg_mask[id[MASK_IDX_W-1:0]])
                    return;
                plen          = rcv_len - MIN_LEN;
                r.frame_id    = id;
                r.frame_seq   = rcv_store[1];
                r.payload_len = PLEN_W'(plen);
                if (plen == 0) begin
                    r.byte_index   = '0;
                    r.payload_byte = '0;
                    r.has_payload  = 1'b0;
                    r.last         = 1'b1;
                    due_results.push_back(r);
                end
                for (int i = 0; i < plen; i++) begin
                    r.byte_index   = BIDX_W'(i);
                    r.payload_byte = rcv_store[i + MIN_LEN];
                    r.has_payload  = 1'b1;
                    r.last         = (i == plen - 1);
                    due_results.push_back(r);
                end
            end
        endcase
    endfunction

    // Register write, mirrored into the shadow copy.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_USE_STUFFING:   cfg_stuffing   = data[0];
            CFG_START_CODE:     cfg_start      = data[BYTE_W-1:0];
            CFG_ESCAPE_CODE:    cfg_escape     = data[BYTE_W-1:0];
            CFG_ESC_START_CODE: cfg_esc_start  = data[BYTE_W-1:0];
            CFG_ESC_ESC_CODE:   cfg_esc_escape = data[BYTE_W-1:0];
            CFG_HANDLER_MASK:   cfg_mask       = data[MASK_W-1:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write a byte-wide register with junk in the unused upper bits.
    task automatic write_code(input logic [CFG_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] code);
        write_reg(idx, {8'($urandom), code});
    endtask

    // One line byte on the input channel, with a random gap ahead of it.
    task automatic send_rx_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if ($urandom_range(0, 15) == 0) rx_idle_on = !rx_idle_on;
        gap = rx_idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        deframe_byte(b);
        bytes_accepted++;
    endtask

    // Drop valid, wait for every owed result, then let the pipeline drain.
    task automatic settle_receiver();
        rx_if.valid <= 1'b0;
        @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Append a byte to the line, escaping it where the current codes call for that.
    function automatic void push_line_byte(input logic [BYTE_W-1:0] b);
        if (cfg_stuffing && b == cfg_start) begin
            line_bytes.push_back(cfg_escape);
            line_bytes.push_back(cfg_esc_start);
        end else if (cfg_stuffing && b == cfg_escape) begin
            line_bytes.push_back(cfg_escape);
            line_bytes.push_back(cfg_esc_escape);
        end else begin
            line_bytes.push_back(b);
        end
    endfunction

    task automatic send_line();
        while (line_bytes.size() != 0) send_rx_byte(line_bytes.pop_front());
    endtask

    // Random payload, now and then salted with the control codes.
    function automatic void fill_payload(input int plen);
        int pick;
        for (int i = 0; i < plen; i++) begin
            pick = $urandom_range(0, 7);
            pay_buf[i] = (pick == 0) ? cfg_start : (pick == 1) ? cfg_escape : 8'($urandom);
        end
    endfunction

    // Mostly short frames, some medium and a few of the largest size.
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return DEF_MAX_DATA;
        if (r < 4) return $urandom_range(9, DEF_MAX_DATA - 1);
        return $urandom_range(0, 8);
    endfunction

    // Whole frame from pay_buf; a nonzero sum_flip corrupts the checksum.
    task automatic send_frame(input logic [BYTE_W-1:0] id, input logic [BYTE_W-1:0] seq,
                              input int plen, input logic [BYTE_W-1:0] sum_flip);
        logic [BYTE_W-1:0] sum;
        sum = id ^ seq ^ sum_flip;
        line_bytes.delete();
        line_bytes.push_back(cfg_start);
        push_line_byte(BYTE_W'(plen + MIN_LEN));
        push_line_byte(id);
        push_line_byte(seq);
        for (int i = 0; i < plen; i++) begin
            push_line_byte(pay_buf[i]);
            sum ^= pay_buf[i];
        end
        push_line_byte(sum);
        send_line();
        frames_sent++;
    endtask

    // Start byte followed by a length outside the legal range.
    task automatic send_bad_length(input logic [BYTE_W-1:0] len);
        send_rx_byte(cfg_start);
        send_rx_byte(len);
    endtask

    // Frame cut short by an escape followed by an unknown code.
    task automatic send_bad_escape();
        logic [BYTE_W-1:0] bad;
        do bad = 8'($urandom); while (bad == cfg_esc_start || bad == cfg_esc_escape);
        line_bytes.delete();
        line_bytes.push_back(cfg_start);
        push_line_byte(BYTE_W'(MIN_LEN + 4));
        push_line_byte(8'($urandom_range(0, 15)));
        line_bytes.push_back(cfg_escape);
        line_bytes.push_back(bad);
        send_line();
    endtask

    // Default codes and an empty mask after reset, then empty, one-byte and full-size frames and ids out of range.
    task automatic test_reset_defaults();
        fill_payload(2);
        send_frame(8'd3, 8'd1, 2, 8'd0);
        settle_receiver();
        write_reg(CFG_HANDLER_MASK, 16'hFFFF);
        send_frame(8'd0, 8'd0, 0, 8'd0);
        fill_payload(DEF_MAX_DATA);
        pay_buf[0] = RST_START_CODE;
        pay_buf[1] = RST_ESCAPE_CODE;
        pay_buf[2] = 8'h00;
        pay_buf[DEF_MAX_DATA - 1] = 8'hFF;
        send_frame(8'd15, 8'hFF, DEF_MAX_DATA, 8'd0);
        fill_payload(1);
        send_frame(8'd16, 8'h55, 1, 8'd0);
        send_frame(8'hFF, 8'hAA, 1, 8'd0);
        send_frame(8'd7, 8'h5A, 1, 8'd0);
        settle_receiver();
        settings_used++;
    endtask

    // Bad checksum, bad lengths, bad escape and a cleared mask bit.
    task automatic test_frame_errors();
        fill_payload(3);
        send_frame(8'd2, 8'd9, 3, 8'h80);
        send_bad_length(8'd0);
        send_bad_length(8'd1);
        send_bad_length(8'(MAX_LEN + 1));
        send_bad_length(8'hFF);
        send_frame(8'd2, 8'd10, 3, 8'd0);
        send_bad_escape();
        send_frame(8'd4, 8'd11, 3, 8'd0);
        settle_receiver();
        write_reg(CFG_HANDLER_MASK, 16'hFFDF);
        send_frame(8'd5, 8'd12, 3, 8'd0);
        send_frame(8'd6, 8'd13, 3, 8'd0);
        settle_receiver();
    endtask

    // Stuffing off with control codes in the body, and an escape left pending across it.
    task automatic test_stuffing_modes();
        write_reg(CFG_USE_STUFFING, 16'hFFFE);
        fill_payload(4);
        pay_buf[0] = cfg_start;
        pay_buf[1] = cfg_escape;
        send_frame(8'd1, 8'h7E, 4, 8'd0);
        settle_receiver();
        write_reg(CFG_USE_STUFFING, 16'h0001);
        send_rx_byte(cfg_escape);
        settle_receiver();
        write_reg(CFG_USE_STUFFING, 16'h0000);
        send_frame(8'd8, 8'd20, 4, 8'd0);
        settle_receiver();
        write_reg(CFG_USE_STUFFING, 16'h0001);
        write_reg(CFG_SPARE_A, 16'h0000);
        write_reg(CFG_SPARE_B, 16'hFFFF);
        send_rx_byte(cfg_esc_escape);
        send_frame(8'd9, 8'd21, 4, 8'd0);
        settle_receiver();
        settings_used += 2;
    endtask

    // Load one register setting for a random traffic phase.
    task automatic configure_phase(input int phase);
        logic [BYTE_W-1:0] s, e, es, ee;
        case (phase)
            0: begin
                s = RST_START_CODE; e = RST_ESCAPE_CODE;
                es = RST_ESC_START_CODE; ee = RST_ESC_ESC_CODE;
            end
            1: begin s = 8'h00; e = 8'hFF; es = 8'h00; ee = 8'hFF; end
            2: begin s = 8'hFF; e = 8'h00; es = 8'hFF; ee = 8'h00; end
            3, 4: begin
                s = 8'($urandom);
                do e = 8'($urandom); while (e == s);
                es = 8'($urandom);
                do ee = 8'($urandom); while (ee == es);
            end
            default: begin
                s = 8'($urandom); e = 8'($urandom); es = 8'($urandom); ee = 8'($urandom);
            end
        endcase
        write_reg(CFG_USE_STUFFING, {15'($urandom), (phase == 4) ? 1'b0 : 1'b1});
        write_code(CFG_START_CODE, s);
        write_code(CFG_ESCAPE_CODE, e);
        write_code(CFG_ESC_START_CODE, es);
        write_code(CFG_ESC_ESC_CODE, ee);
        write_reg(CFG_HANDLER_MASK, (phase == 1) ? 16'hFFFF : (phase == 2) ? 16'h0000 :
                  16'($urandom) | 16'hC003);
        settings_used++;
    endtask

    // Mostly well-formed frames with random content; the rest broken frames and noise.
    task automatic test_random_traffic();
        int                first;
        int                kind;
        logic [BYTE_W-1:0] id;
        logic [BYTE_W-1:0] bad;
        int                plen;
        for (int phase = 0; phase < 6; phase++) begin
            configure_phase(phase);
            first = bytes_accepted;
            while (bytes_accepted - first < PHASE_BYTES) begin
                kind = $urandom_range(0, 19);
                if (kind < 16) begin
                    id   = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
                    plen = pick_length();
                    fill_payload(plen);
                    send_frame(id, 8'($urandom), plen,
                               (kind == 0) ? 8'($urandom_range(1, 255)) : 8'd0);
                end else if (kind == 16) begin
                    bad = $urandom_range(0, 1) ? 8'($urandom_range(0, MIN_LEN - 1))
                                               : 8'($urandom_range(MAX_LEN + 1, 255));
                    send_bad_length(bad);
                end else if (kind == 17) begin
                    send_bad_escape();
                end else begin
                    repeat ($urandom_range(1, 4)) send_rx_byte(8'($urandom));
                end
            end
            settle_receiver();
        end
    endtask

    // Result ready with random stalls; some stretches never stall.
    initial begin : result_ready_driver
        int stall;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 15) == 0) res_stall_on = !res_stall_on;
            stall = res_stall_on ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_if.valid && res_if.ready));
        end
    end

    function automatic void compare_field(input string name, input logic [BYTE_W-1:0] want,
                                          input logic [BYTE_W-1:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Check each result transaction against the oldest owed result.
    always @(posedge i_clk) begin : result_checker
        t_tfr_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_checked++;
            if (due_results.size() == 0) begin
                error_count++;
                $display("%0t: result with none expected, expected nothing, actual %h",
                         $time, res_if.data);
            end else begin
                want = due_results.pop_front();
                compare_field("frame_id", want.frame_id, res_if.data.frame_id);
                compare_field("frame_seq", want.frame_seq, res_if.data.frame_seq);
                compare_field("payload_len", want.payload_len, res_if.data.payload_len);
                compare_field("byte_index", want.byte_index, res_if.data.byte_index);
                compare_field("payload_byte", want.payload_byte, res_if.data.payload_byte);
                compare_field("has_payload", want.has_payload, res_if.data.has_payload);
                compare_field("last", want.last, res_if.data.last);
            end
        end
    end

    // Main sequence.
    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_USE_STUFFING;
        i_cfg_data    <= '0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        res_if.ready  <= 1'b0;
        cfg_stuffing   = RST_USE_STUFFING;
        cfg_start      = RST_START_CODE;
        cfg_escape     = RST_ESCAPE_CODE;
        cfg_esc_start  = RST_ESC_START_CODE;
        cfg_esc_escape = RST_ESC_ESC_CODE;
        cfg_mask       = RST_HANDLER_MASK;
        restart_hunt();
        rcv_len = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_frame_errors();
        test_stuffing_modes();
        test_random_traffic();

        $display("Ran %0d frames in %0d line bytes under %0d register settings; %0d results checked.",
                 frames_sent, bytes_accepted, settings_used, results_checked);
        $display("Covered stuffing on and off, extreme codes, bad lengths, escapes and checksums.");
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
